// File: rtl/core/bmhpq_pkg.sv
package bmhpq_pkg;

   localparam int HEAP_DEPTH_DEF = 64;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_REMOVED  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic        action;
      logic [15:0] new_key;
      logic [15:0] new_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_key;
      logic [15:0] out_tag;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key;
      logic [15:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: rtl/core/bmhpq_ram.sv
module bmhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_a_addr,
   output logic [WIDTH-1:0] rd_a_data,
   input  logic [AddrW-1:0] rd_b_addr,
   output logic [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// File: rtl/core/binary_max_heap_priority_queue.sv
// Binary max-heap priority queue of (key, tag) entries held in one dual-read RAM. An enqueue
// item holds the new entry in a register and moves it up past strictly smaller parents; a
// dequeue item returns the root and moves the last entry down towards the strictly larger
// child, left child winning ties. Each level is a RAM read, then a compare and write. A full
// enqueue or an empty dequeue reads no RAM and goes straight to the result.
// One item is worked at a time and req_ready is low meanwhile; the result waits in an output
// register, and a result still held there stalls the block before it returns to idle.
module binary_max_heap_priority_queue #(
   parameter int HEAP_DEPTH = bmhpq_pkg::HEAP_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bmhpq_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bmhpq_pkg::rsp_type  rsp_data
);

   import bmhpq_pkg::*;

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int IW = AW + 2;
   localparam int EW = CW + 7;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP      = 3'd1;
   localparam logic [2:0] S_UP_CMP  = 3'd2;
   localparam logic [2:0] S_DQ_LOAD = 3'd3;
   localparam logic [2:0] S_DN      = 3'd4;
   localparam logic [2:0] S_DN_CMP  = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   entry_type     mov_ff, mov_in;
   entry_type     top_ff, top_in;
   logic [1:0]    status_ff, status_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_entry;
   logic [AW-1:0]      rd_a_addr, rd_b_addr;
   logic [ENTRY_W-1:0] rd_a_data, rd_b_data;
   entry_type          rd_a_entry, rd_b_entry;

   logic [AW-1:0] parent_idx;
   logic [CW-1:0] last_idx;
   logic [IW-1:0] left_idx, right_idx, n_ext;
   logic          right_ok, take_left, take_right;
   logic [15:0]   best_key;
   logic [EW-1:0] cnt_wide;

   assign rd_a_entry = entry_type'(rd_a_data);
   assign rd_b_entry = entry_type'(rd_b_data);

   assign parent_idx = AW'(pos_ff - AW'(1)) >> 1;
   assign last_idx   = count_ff - CW'(1);
   assign left_idx   = IW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + IW'(1);
   assign n_ext      = IW'(count_ff);
   assign right_ok   = right_idx < n_ext;
   assign take_left  = mov_ff.key < rd_a_entry.key;
   assign best_key   = take_left ? rd_a_entry.key : mov_ff.key;
   assign take_right = right_ok && (best_key < rd_b_entry.key);
   assign cnt_wide   = EW'(count_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      mov_in       = mov_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_entry     = mov_ff;
      rd_a_addr    = parent_idx;
      rd_b_addr    = AW'(right_idx);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mov_in = '{key: req_data.new_key, tag: req_data.new_tag};
               top_in = '0;
               pos_in = '0;
               if (req_data.action == ACT_ENQUEUE) begin
                  if (count_ff == CW'(HEAP_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_INSERTED;
                     pos_in    = count_ff[AW-1:0];
                     count_in  = count_ff + CW'(1);
                     state_in  = S_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_REMOVED;
                     rd_a_addr = '0;
                     rd_b_addr = last_idx[AW-1:0];
                     count_in  = last_idx;
                     state_in  = S_DQ_LOAD;
                  end
               end
            end
         end
         S_UP: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_a_addr = parent_idx;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_a_entry.key < mov_ff.key) begin
               wr_entry = rd_a_entry;
               pos_in   = parent_idx;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DQ_LOAD: begin
            top_in   = rd_a_entry;
            mov_in   = rd_b_entry;
            state_in = S_DN;
         end
         S_DN: begin
            if (left_idx >= n_ext) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_a_addr = AW'(left_idx);
               rd_b_addr = AW'(right_idx);
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (take_right) begin
               wr_entry = rd_b_entry;
               pos_in   = AW'(right_idx);
               state_in = S_DN;
            end else if (take_left) begin
               wr_entry = rd_a_entry;
               pos_in   = AW'(left_idx);
               state_in = S_DN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status      = status_ff;
               rsp_in.out_key     = top_ff.key;
               rsp_in.out_tag     = top_ff.tag;
               rsp_in.entry_count = cnt_wide[6:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      mov_ff    <= mov_in;
      top_ff    <= top_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   bmhpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (ENTRY_W'(wr_entry)),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("entry count beyond heap depth");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_ENQUEUE && count_ff != CW'(HEAP_DEPTH))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("enqueue did not grow the count");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_REMOVED) |-> (rsp_data.out_key == '0
      && rsp_data.out_tag == '0))
      else $error("payload not zero on a non-removal result");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_UP || state_ff == S_UP_CMP || state_ff == S_DN
      || state_ff == S_DN_CMP))
      else $error("ram written outside a sift step");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bmhpq_pkg::*;

   class pq_tracker;
      logic [15:0] slot_key [HEAP_DEPTH_DEF];
      logic [15:0] slot_tag [HEAP_DEPTH_DEF];
      int unsigned held;
      rsp_type     pending_results [$];
      int          errors;

      function new();
         held = 0;
         errors = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [15:0] k;
         logic [15:0] t;
         k = slot_key[a];
         t = slot_tag[a];
         slot_key[a] = slot_key[b];
         slot_tag[a] = slot_tag[b];
         slot_key[b] = k;
         slot_tag[b] = t;
      endfunction

      function void note_request(req_type r);
         rsp_type     res;
         int unsigned pos;
         int unsigned parent;
         int unsigned left;
         int unsigned right;
         int unsigned best;
         res = '0;
         if (r.action == ACT_ENQUEUE) begin
            if (held < HEAP_DEPTH_DEF) begin
               slot_key[held] = r.new_key;
               slot_tag[held] = r.new_tag;
               pos = held;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (slot_key[parent] < slot_key[pos]) begin
                     swap_slots(parent, pos);
                     pos = parent;
                  end else begin
                     break;
                  end
               end
               held++;
               res.status = ST_INSERTED;
            end else begin
               res.status = ST_FULL;
            end
         end else if (held > 0) begin
            res.out_key = slot_key[0];
            res.out_tag = slot_tag[0];
            held--;
            slot_key[0] = slot_key[held];
            slot_tag[0] = slot_tag[held];
            pos = 0;
            while (2 * pos + 1 < held) begin
               left = 2 * pos + 1;
               right = left + 1;
               best = pos;
               if (slot_key[best] < slot_key[left]) best = left;
               if (right < held && slot_key[best] < slot_key[right]) best = right;
               if (best == pos) break;
               swap_slots(best, pos);
               pos = best;
            end
            res.status = ST_REMOVED;
         end else begin
            res.status = ST_EMPTY;
         end
         res.entry_count = held[6:0];
         pending_results.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d key %h",
                     $time, got.status, got.out_key);
            $display("%0t: unexpected result tag %h count %0d", $time, got.out_tag,
                     got.entry_count);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.out_key !== want.out_key) begin
            $display("%0t: out_key expected %h actual %h", $time, want.out_key, got.out_key);
            errors++;
         end
         if (got.out_tag !== want.out_tag) begin
            $display("%0t: out_tag expected %h actual %h", $time, want.out_tag, got.out_tag);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     got.entry_count);
            errors++;
         end
      endfunction
   endclass

   localparam int HOLD_CYCLES = 600;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bit        calm = 1'b0;
   int        hold_asks = 0;
   pq_tracker tracker = new();

   binary_max_heap_priority_queue #(.HEAP_DEPTH(HEAP_DEPTH_DEF)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_request(req_data);
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_data);
      end
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin
      int served;
      served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != served) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
         end
      end
   end

   task automatic send_item(input req_type item);
      while (!calm && $urandom_range(0, 99) < 34) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic req_type random_item(int enq_pct, bit narrow_keys);
      req_type it;
      it.action = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
      it.new_key = narrow_keys ? 16'($urandom_range(0, 7)) : 16'($urandom);
      it.new_tag = 16'($urandom);
      return it;
   endfunction

   initial begin
      int sent;
      int phase;
      int span;
      int enq_pct;
      bit narrow;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty heap, key and tag extremes, equal keys
      send_item(req_type'{ACT_DEQUEUE, 16'hffff, 16'hffff});
      send_item(req_type'{ACT_ENQUEUE, 16'h0000, 16'h0000});
      send_item(req_type'{ACT_ENQUEUE, 16'hffff, 16'hffff});
      send_item(req_type'{ACT_ENQUEUE, 16'h8000, 16'h0001});
      send_item(req_type'{ACT_ENQUEUE, 16'h8000, 16'h0002});
      send_item(req_type'{ACT_ENQUEUE, 16'h8000, 16'h0003});
      send_item(req_type'{ACT_ENQUEUE, 16'h0001, 16'haaaa});
      send_item(req_type'{ACT_ENQUEUE, 16'h7fff, 16'h5555});
      send_item(req_type'{ACT_ENQUEUE, 16'h8000, 16'h0004});
      repeat (9) send_item(req_type'{ACT_DEQUEUE, 16'h0000, 16'h0000});

      sent = 0;
      phase = 0;
      while (sent < 1032) begin
         span = $urandom_range(80, 150);
         case (phase % 4)
            0: enq_pct = 95;
            1: enq_pct = 50;
            2: enq_pct = 5;
            default: enq_pct = 60;
         endcase
         narrow = 1'($urandom_range(0, 1));
         calm = (phase == 3);
         if (phase == 1) hold_asks++;
         for (int i = 0; i < span && sent < 1032; i++) begin
            send_item(random_item(enq_pct, narrow));
            sent++;
         end
         if (phase % 3 == 2) wait_drained();
         phase++;
      end
      calm = 1'b0;

      wait_drained();
      repeat (40) @(negedge clock);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
